/* hw/rtl/pgalloc_pkg.sv */
// Shared types, constants and helpers for the page allocator core.
// Depends on nothing; the core refers to it by scoped names.
package pgalloc_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BITS  = 12;
  localparam int COUNT_BITS = 8;

  localparam int IDX_W     = $clog2(NUM_PAGES);
  localparam int DEPTH_W   = IDX_W + 1;
  localparam int ADDR_W    = 32;
  localparam int FREE_W    = 16;
  localparam int REFCNT_W  = 8;
  localparam int STATUS_W  = 3;

  localparam logic [ADDR_W-1:0]   START_RST = 32'h8010_0000;
  localparam logic [ADDR_W-1:0]   STOP_RST  = 32'h8800_0000;
  localparam logic [ADDR_W:0]     PAGE_MASK = (ADDR_W+1)'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_ADDREF = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_OOM      = 3'd1,
    STS_BAD_ADDR = 3'd2,
    STS_ZERO     = 3'd3,
    STS_SAT      = 3'd4
  } status_t;

  typedef enum logic {
    REG_START = 1'b0,
    REG_STOP  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_POP,
    S_MOD,
    S_RANGE,
    S_CLEAR,
    S_INIT_OUT
  } state_t;

  // Round a start address up to the next page boundary (33 bits: may overflow).
  function automatic logic [ADDR_W:0] round_base(logic [ADDR_W-1:0] start);
    logic [ADDR_W:0] sum;
    sum = {1'b0, start} + PAGE_MASK;
    return sum & ~PAGE_MASK;
  endfunction

  // Whole pages between base and stop, clamped to the store depth.
  function automatic logic [DEPTH_W-1:0] range_pages(logic [ADDR_W:0] base,
                                                      logic [ADDR_W-1:0] stop);
    logic [ADDR_W:0]           span;
    logic [ADDR_W-PAGE_BITS:0] n;
    if (!base[ADDR_W] && (base < {1'b0, stop})) begin
      span = {1'b0, stop} - base;
    end else begin
      span = '0;
    end
    n = span[ADDR_W:PAGE_BITS];
    if (n > NUM_PAGES) begin
      return DEPTH_W'(NUM_PAGES);
    end
    return DEPTH_W'(n);
  endfunction

  localparam logic [ADDR_W:0]    RST_BASE  = round_base(START_RST);
  localparam logic [DEPTH_W-1:0] RST_PAGES = range_pages(RST_BASE, STOP_RST);
  localparam logic [IDX_W-1:0]   RST_NEXT  =
      (RST_PAGES != '0) ? IDX_W'(RST_PAGES - 1'b1) : '0;

endpackage

/* hw/rtl/page_allocator_with_refcount_core.sv */
// Page allocator with per-page reference counts: top level; uses pgalloc_pkg.
// An accepted request goes to S_LOOK, which registers the result of a fresh allocate or out
//   of memory; an allocate from the returned stack goes on to S_POP, a free or an add reference
//   to S_MOD (registered count read, write-back), an init to S_RANGE, a clearing pass of one
//   count entry per cycle and S_INIT_OUT. No new request is taken until the last one is done.
// Reset (rst_n low, synchronous): registers take reset values, then a clearing pass over all
//   NUM_PAGES entries zeroes the count memory; no request is taken until it ends.
module page_allocator_with_refcount_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [pgalloc_pkg::ADDR_W-1:0]       in_address,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pgalloc_pkg::STATUS_W-1:0]     out_status,
  output logic [pgalloc_pkg::ADDR_W-1:0]       out_page_address,
  output logic [pgalloc_pkg::REFCNT_W-1:0]     out_ref_count,
  output logic                                 out_page_freed,
  output logic [pgalloc_pkg::FREE_W-1:0]       out_free_pages,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int IDX_W   = pgalloc_pkg::IDX_W;
  localparam int DEPTH_W = pgalloc_pkg::DEPTH_W;
  localparam int CNT_W   = pgalloc_pkg::COUNT_BITS;
  localparam int AW      = pgalloc_pkg::ADDR_W;
  localparam int PB      = pgalloc_pkg::PAGE_BITS;

  // ---------------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------------
  pgalloc_pkg::state_t state_r, state_nxt;
  pgalloc_pkg::cmd_t   cmd_r;
  logic [AW-1:0]       addr_r;

  logic [AW-1:0]       start_r, stop_r;
  logic [AW:0]         range_base_r, range_base_nxt;
  logic [DEPTH_W-1:0]  range_pages_r, range_pages_nxt;

  logic [DEPTH_W-1:0]  stack_depth_r, stack_depth_nxt;
  logic [DEPTH_W-1:0]  fresh_left_r, fresh_left_nxt;
  logic [IDX_W-1:0]    next_fresh_r, next_fresh_nxt;

  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic                init_pend_r, init_pend_nxt;

  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                ok_r, ok_nxt;

  logic                          out_valid_r;
  logic [pgalloc_pkg::STATUS_W-1:0] out_status_r;
  logic [AW-1:0]                 out_page_address_r;
  logic [pgalloc_pkg::REFCNT_W-1:0] out_ref_count_r;
  logic                          out_page_freed_r;
  logic [pgalloc_pkg::FREE_W-1:0]   out_free_pages_r;

  // ---------------------------------------------------------------------------
  // Memories: per-page count store and the stack of returned page indices.
  // Both have registered read data.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_mem [pgalloc_pkg::NUM_PAGES];
  logic             cnt_we, cnt_re;
  logic [IDX_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata_r;

  logic [IDX_W-1:0] stk_mem [pgalloc_pkg::NUM_PAGES];
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata_r;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration port: writes land on the access phase; reads are immediate.
  // ---------------------------------------------------------------------------
  logic                  cfg_wr;
  pgalloc_pkg::reg_idx_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = pgalloc_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      pgalloc_pkg::REG_START: prdata = start_r;
      pgalloc_pkg::REG_STOP:  prdata = stop_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= pgalloc_pkg::START_RST;
      stop_r  <= pgalloc_pkg::STOP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        pgalloc_pkg::REG_START: start_r <= pwdata;
        pgalloc_pkg::REG_STOP:  stop_r  <= pwdata;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Address decode for free and add reference against the latched range.
  // The offset keeps the borrow of the subtraction; an explicit compare is the below-base check.
  // ---------------------------------------------------------------------------
  logic [AW:0]      loc_diff;
  logic [AW-PB:0]   loc_off;
  logic             loc_ok;
  logic [IDX_W-1:0] loc_idx;

  assign loc_diff = {1'b0, addr_r} - range_base_r;
  assign loc_off  = loc_diff[AW:PB];
  assign loc_idx  = IDX_W'(loc_off);
  assign loc_ok   = (addr_r[PB-1:0] == '0) && ({1'b0, addr_r} >= range_base_r) &&
                    (loc_off < range_pages_r);

  // Byte address of an allocated page: popped index or the next fresh one.
  logic [IDX_W-1:0] pa_idx;
  logic [AW:0]      pa_sum;

  assign pa_idx = (state_r == pgalloc_pkg::S_POP) ? stk_rdata_r : next_fresh_r;
  assign pa_sum = range_base_r + ((AW+1)'(pa_idx) << PB);

  // Free pages now: stack entries plus pages never handed out.
  logic [DEPTH_W:0] free_total_cur, free_total_nxt;

  assign free_total_cur = {1'b0, stack_depth_r} + {1'b0, fresh_left_r};
  assign free_total_nxt = {1'b0, stack_depth_nxt} + {1'b0, fresh_left_nxt};

  // ---------------------------------------------------------------------------
  // Sequencer: next state, memory accesses and the result to be registered.
  // A final step only commits when the result register can take its result.
  // ---------------------------------------------------------------------------
  logic                             emit, out_load;
  pgalloc_pkg::status_t             res_status;
  logic [AW-1:0]                    res_paddr;
  logic [CNT_W-1:0]                 res_cnt;
  logic                             res_freed;
  logic [CNT_W-1:0]                 cnt_dec, cnt_inc;
  logic [DEPTH_W-1:0]               pages_calc;

  assign emit    = !out_valid_r || out_ready;
  assign cnt_dec = cnt_rdata_r - 1'b1;
  assign cnt_inc = cnt_rdata_r + 1'b1;
  assign pages_calc = pgalloc_pkg::range_pages(range_base_r, stop_r);

  always_comb begin
    state_nxt       = state_r;
    range_base_nxt  = range_base_r;
    range_pages_nxt = range_pages_r;
    stack_depth_nxt = stack_depth_r;
    fresh_left_nxt  = fresh_left_r;
    next_fresh_nxt  = next_fresh_r;
    clr_idx_nxt     = clr_idx_r;
    init_pend_nxt   = init_pend_r;
    idx_nxt         = idx_r;
    ok_nxt          = ok_r;

    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = loc_idx;
    stk_we    = 1'b0;
    stk_waddr = stack_depth_r[IDX_W-1:0];
    stk_wdata = idx_r;
    stk_re    = 1'b0;
    stk_raddr = IDX_W'(stack_depth_r - 1'b1);

    out_load   = 1'b0;
    res_status = pgalloc_pkg::STS_OK;
    res_paddr  = '0;
    res_cnt    = '0;
    res_freed  = 1'b0;

    unique case (state_r)
      pgalloc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pgalloc_pkg::S_LOOK;
        end
      end

      pgalloc_pkg::S_LOOK: begin
        unique case (cmd_r)
          pgalloc_pkg::CMD_ALLOC: begin
            if (free_total_cur == '0) begin
              if (emit) begin
                out_load   = 1'b1;
                res_status = pgalloc_pkg::STS_OOM;
                state_nxt  = pgalloc_pkg::S_IDLE;
              end
            end else if (stack_depth_r != '0) begin
              // pop: read the top entry, commit its count in S_POP
              stk_re          = 1'b1;
              stack_depth_nxt = stack_depth_r - 1'b1;
              state_nxt       = pgalloc_pkg::S_POP;
            end else if (emit) begin
              cnt_we         = 1'b1;
              cnt_waddr      = next_fresh_r;
              cnt_wdata      = CNT_W'(1);
              fresh_left_nxt = fresh_left_r - 1'b1;
              if (next_fresh_r != '0) begin
                next_fresh_nxt = next_fresh_r - 1'b1;
              end
              out_load  = 1'b1;
              res_paddr = pa_sum[AW-1:0];
              res_cnt   = CNT_W'(1);
              state_nxt = pgalloc_pkg::S_IDLE;
            end
          end
          pgalloc_pkg::CMD_FREE, pgalloc_pkg::CMD_ADDREF: begin
            cnt_re    = 1'b1;
            idx_nxt   = loc_idx;
            ok_nxt    = loc_ok;
            state_nxt = pgalloc_pkg::S_MOD;
          end
          pgalloc_pkg::CMD_INIT: begin
            range_base_nxt = pgalloc_pkg::round_base(start_r);
            state_nxt      = pgalloc_pkg::S_RANGE;
          end
        endcase
      end

      pgalloc_pkg::S_POP: begin
        if (emit) begin
          cnt_we    = 1'b1;
          cnt_waddr = stk_rdata_r;
          cnt_wdata = CNT_W'(1);
          out_load  = 1'b1;
          res_paddr = pa_sum[AW-1:0];
          res_cnt   = CNT_W'(1);
          state_nxt = pgalloc_pkg::S_IDLE;
        end
      end

      pgalloc_pkg::S_MOD: begin
        if (emit) begin
          out_load  = 1'b1;
          res_paddr = addr_r;
          state_nxt = pgalloc_pkg::S_IDLE;
          if (!ok_r) begin
            res_status = pgalloc_pkg::STS_BAD_ADDR;
          end else if (cmd_r == pgalloc_pkg::CMD_FREE) begin
            if (cnt_rdata_r == '0) begin
              res_status = pgalloc_pkg::STS_ZERO;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_dec;
              res_cnt   = cnt_dec;
              if (cnt_dec == '0) begin
                res_freed = 1'b1;
                // push the page back; drop it when the stack is full
                if (stack_depth_r < DEPTH_W'(pgalloc_pkg::NUM_PAGES)) begin
                  stk_we          = 1'b1;
                  stack_depth_nxt = stack_depth_r + 1'b1;
                end
              end
            end
          end else begin
            if (cnt_rdata_r == pgalloc_pkg::COUNT_MAX) begin
              res_status = pgalloc_pkg::STS_SAT;
              res_cnt    = cnt_rdata_r;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_inc;
              res_cnt   = cnt_inc;
            end
          end
        end
      end

      pgalloc_pkg::S_RANGE: begin
        range_pages_nxt = pages_calc;
        fresh_left_nxt  = pages_calc;
        next_fresh_nxt  = (pages_calc != '0) ? IDX_W'(pages_calc - 1'b1) : '0;
        stack_depth_nxt = '0;
        clr_idx_nxt     = '0;
        init_pend_nxt   = 1'b1;
        state_nxt       = pgalloc_pkg::S_CLEAR;
      end

      pgalloc_pkg::S_CLEAR: begin
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(pgalloc_pkg::NUM_PAGES - 1)) begin
          init_pend_nxt = 1'b0;
          state_nxt     = init_pend_r ? pgalloc_pkg::S_INIT_OUT : pgalloc_pkg::S_IDLE;
        end
      end

      pgalloc_pkg::S_INIT_OUT: begin
        if (emit) begin
          out_load  = 1'b1;
          state_nxt = pgalloc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pgalloc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == pgalloc_pkg::S_IDLE);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pgalloc_pkg::S_CLEAR;
      range_base_r  <= pgalloc_pkg::RST_BASE;
      range_pages_r <= pgalloc_pkg::RST_PAGES;
      stack_depth_r <= '0;
      fresh_left_r  <= pgalloc_pkg::RST_PAGES;
      next_fresh_r  <= pgalloc_pkg::RST_NEXT;
      clr_idx_r     <= '0;
      init_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      range_base_r  <= range_base_nxt;
      range_pages_r <= range_pages_nxt;
      stack_depth_r <= stack_depth_nxt;
      fresh_left_r  <= fresh_left_nxt;
      next_fresh_r  <= next_fresh_nxt;
      clr_idx_r     <= clr_idx_nxt;
      init_pend_r   <= init_pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload: hold the request and the result; no reset needed
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= pgalloc_pkg::cmd_t'(in_command);
      addr_r <= in_address;
    end
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
    if (out_load) begin
      out_status_r       <= res_status;
      out_page_address_r <= res_paddr;
      out_ref_count_r    <= pgalloc_pkg::REFCNT_W'(res_cnt);
      out_page_freed_r   <= res_freed;
      out_free_pages_r   <= pgalloc_pkg::FREE_W'(free_total_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_page_address_r;
  assign out_ref_count    = out_ref_count_r;
  assign out_page_freed   = out_page_freed_r;
  assign out_free_pages   = out_free_pages_r;

`ifndef ASSERT_OFF
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_depth_r <= DEPTH_W'(pgalloc_pkg::NUM_PAGES))
    else $error("returned stack deeper than the page store");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_left_r <= range_pages_r)
    else $error("fresh page count exceeds the latched range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_freed) |->
      (out_ref_count == '0 && out_status == pgalloc_pkg::STS_OK))
    else $error("page returned to the pool with a nonzero count");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

/* dv/page_allocator_with_refcount_watch.sv */
// Result predictor and comparator for the page allocator core.
// Watches the request, result and register channels; depends on pgalloc_pkg.
`timescale 1ns / 100ps

module page_allocator_with_refcount_watch (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       in_command,
  input  logic [pgalloc_pkg::ADDR_W-1:0]   in_address,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [pgalloc_pkg::STATUS_W-1:0] out_status,
  input  logic [pgalloc_pkg::ADDR_W-1:0]   out_page_address,
  input  logic [pgalloc_pkg::REFCNT_W-1:0] out_ref_count,
  input  logic                             out_page_freed,
  input  logic [pgalloc_pkg::FREE_W-1:0]   out_free_pages,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  input  logic                             pready,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int NUM_PAGES  = pgalloc_pkg::NUM_PAGES;
  localparam int PAGE_BITS  = pgalloc_pkg::PAGE_BITS;
  localparam int COUNT_BITS = pgalloc_pkg::COUNT_BITS;
  localparam int IDX_W      = pgalloc_pkg::IDX_W;
  localparam int ADDR_W     = pgalloc_pkg::ADDR_W;
  localparam int FREE_W     = pgalloc_pkg::FREE_W;
  localparam int REFCNT_W   = pgalloc_pkg::REFCNT_W;

  typedef struct packed {
    pgalloc_pkg::status_t  status;
    logic [ADDR_W-1:0]     page;
    logic [REFCNT_W-1:0]   count;
    logic                  freed;
    logic [FREE_W-1:0]     free_pages;
  } page_result_t;

  logic [ADDR_W-1:0]     start_reg;
  logic [ADDR_W-1:0]     stop_reg;
  logic [COUNT_BITS-1:0] page_counts [NUM_PAGES];
  logic [IDX_W-1:0]      returned_pages [NUM_PAGES];
  int unsigned           depth;
  int unsigned           next_fresh;
  int unsigned           fresh_left;
  int unsigned           free_total;
  int unsigned           range_count;
  logic [ADDR_W:0]       range_base;
  page_result_t          pending_results [$];
  int                    fails = 0;

  // Latch the page range from the registers and clear every count.
  function automatic void rebuild_range();
    logic [ADDR_W:0] m;
    logic [ADDR_W:0] b;
    logic [ADDR_W:0] span;
    int unsigned     n;
    m = (33'd1 << PAGE_BITS) - 33'd1;
    b = ({1'b0, start_reg} + m) & ~m;
    n = 0;
    if (!b[ADDR_W] && b < {1'b0, stop_reg}) begin
      span = {1'b0, stop_reg} - b;
      n = span >> PAGE_BITS;
    end
    if (n > NUM_PAGES) n = NUM_PAGES;
    range_base  = b;
    range_count = n;
    for (int i = 0; i < NUM_PAGES; i++) page_counts[i] = '0;
    depth      = 0;
    fresh_left = n;
    next_fresh = (n != 0) ? n - 1 : 0;
    free_total = n;
  endfunction

  // Apply one request to the predicted state and return its result.
  function automatic page_result_t apply_page_op(pgalloc_pkg::cmd_t c,
                                                 logic [ADDR_W-1:0] a);
    page_result_t    r;
    logic [ADDR_W:0] off;
    int unsigned     idx;
    int unsigned     cnt;
    bit              hit;
    r = '{status: pgalloc_pkg::STS_OK, page: '0, count: '0, freed: 1'b0,
          free_pages: '0};
    case (c)
      pgalloc_pkg::CMD_ALLOC: begin
        if (free_total == 0) begin
          r.status = pgalloc_pkg::STS_OOM;
        end else begin
          if (depth > 0) begin
            depth--;
            idx = returned_pages[depth];
          end else begin
            idx = next_fresh % NUM_PAGES;
            fresh_left--;
            if (next_fresh > 0) next_fresh--;
          end
          free_total = depth + fresh_left;
          page_counts[idx] = COUNT_BITS'(1);
          off = range_base + ((ADDR_W+1)'(idx) << PAGE_BITS);
          r.page  = off[ADDR_W-1:0];
          r.count = REFCNT_W'(1);
        end
      end
      pgalloc_pkg::CMD_FREE, pgalloc_pkg::CMD_ADDREF: begin
        r.page = a;
        off = {1'b0, a} - range_base;
        hit = (a[PAGE_BITS-1:0] == '0) && ({1'b0, a} >= range_base) &&
              ((off >> PAGE_BITS) < range_count);
        if (!hit) begin
          r.status = pgalloc_pkg::STS_BAD_ADDR;
        end else begin
          idx = off >> PAGE_BITS;
          cnt = page_counts[idx];
          if (c == pgalloc_pkg::CMD_FREE) begin
            if (cnt == 0) begin
              r.status = pgalloc_pkg::STS_ZERO;
            end else begin
              cnt--;
              page_counts[idx] = COUNT_BITS'(cnt);
              r.count = REFCNT_W'(cnt);
              if (cnt == 0) begin
                r.freed = 1'b1;
                // a push onto a full stack is dropped
                if (depth < NUM_PAGES) begin
                  returned_pages[depth] = IDX_W'(idx);
                  depth++;
                end
                free_total = depth + fresh_left;
              end
            end
          end else begin
            if (cnt >= pgalloc_pkg::COUNT_MAX) begin
              r.status = pgalloc_pkg::STS_SAT;
            end else begin
              cnt++;
              page_counts[idx] = COUNT_BITS'(cnt);
            end
            r.count = REFCNT_W'(cnt);
          end
        end
      end
      default: rebuild_range();
    endcase
    r.free_pages = FREE_W'(free_total);
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (!rst_n) begin
      start_reg = pgalloc_pkg::START_RST;
      stop_reg  = pgalloc_pkg::STOP_RST;
      rebuild_range();
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // compare first: a result never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        got = '{status: pgalloc_pkg::status_t'(out_status), page: out_page_address,
                count: out_ref_count, freed: out_page_freed,
                free_pages: out_free_pages};
        // fields in order: status/page/count/freed/free pages
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t: result with none awaited: %0d/%h/%0d/%0b/%0d",
                   $time, got.status, got.page, got.count, got.freed, got.free_pages);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: expected %0d/%h/%0d/%0b/%0d, actual %0d/%h/%0d/%0b/%0d",
                     $time, want.status, want.page, want.count, want.freed,
                     want.free_pages, got.status, got.page, got.count, got.freed,
                     got.free_pages);
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_page_op(pgalloc_pkg::cmd_t'(in_command),
                                                in_address));
      if (psel && penable && pwrite && pready) begin
        case (pgalloc_pkg::reg_idx_t'(paddr[2]))
          pgalloc_pkg::REG_START: start_reg = pwdata;
          pgalloc_pkg::REG_STOP:  stop_reg  = pwdata;
          default:   ;
        endcase
      end
      outstanding <= pending_results.size();
      mismatches  <= fails;
    end
  end

endmodule

/* dv/page_allocator_with_refcount_core_tb.sv */
// Top of the page allocator testbench: clock, reset, request and register stimulus.
// Instantiates the core and page_allocator_with_refcount_watch; depends on pgalloc_pkg.
`timescale 1ns / 100ps

module page_allocator_with_refcount_core_tb;

  localparam int NUM_PAGES = pgalloc_pkg::NUM_PAGES;
  localparam int PAGE_BITS = pgalloc_pkg::PAGE_BITS;
  localparam int ADDR_W    = pgalloc_pkg::ADDR_W;
  localparam int STATUS_W  = pgalloc_pkg::STATUS_W;
  localparam int REFCNT_W  = pgalloc_pkg::REFCNT_W;
  localparam int FREE_W    = pgalloc_pkg::FREE_W;

  // An init walks every count entry, so the longest quiet stretch is one init
  // plus receiver stalls; allow several times that.
  localparam int WATCHDOG_LIMIT = 4 * (NUM_PAGES + 3) + 20000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [1:0]          in_command = pgalloc_pkg::CMD_ALLOC;
  logic [ADDR_W-1:0]   in_address = '0;
  logic                out_ready  = 1'b0;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [2:0]          paddr      = '0;
  logic [31:0]         pwdata     = '0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_page_address;
  logic [REFCNT_W-1:0] out_ref_count;
  logic                out_page_freed;
  logic [FREE_W-1:0]   out_free_pages;
  logic [31:0]         prdata;
  logic                pready;

  int          mismatches;
  int          outstanding;
  int          send_idle   = 25;
  int          recv_idle   = 71;
  int          sent        = 0;
  int          idle_cycles = 0;
  logic [31:0] cur_start   = pgalloc_pkg::START_RST;
  logic [31:0] cur_stop    = pgalloc_pkg::STOP_RST;
  logic [32:0] lat_base    = pgalloc_pkg::RST_BASE;
  int unsigned lat_pages   = pgalloc_pkg::RST_PAGES;

  page_allocator_with_refcount_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_ref_count    (out_ref_count),
    .out_page_freed   (out_page_freed),
    .out_free_pages   (out_free_pages),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  page_allocator_with_refcount_watch watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_ref_count    (out_ref_count),
    .out_page_freed   (out_page_freed),
    .out_free_pages   (out_free_pages),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always #1 clk = ~clk;

  // Stall the result channel at random, at the rate of the current idling mode.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Present one request and hold it until the core takes it. An init latches
  // the register values, so mirror the new range for address selection.
  task automatic send_request(pgalloc_pkg::cmd_t c, logic [31:0] a);
    int          gap;
    logic [32:0] m;
    logic [32:0] b;
    logic [32:0] span;
    int unsigned n;
    gap = 0;
    // receiver idles first, then the sender, then neither
    if (sent < 170) begin
      send_idle = 25;
      recv_idle = 71;
    end else if (sent < 340) begin
      send_idle = 71;
      recv_idle = 25;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= c;
    in_address <= a;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (c == pgalloc_pkg::CMD_INIT) begin
      m = (33'd1 << PAGE_BITS) - 33'd1;
      b = ({1'b0, cur_start} + m) & ~m;
      n = 0;
      if (!b[32] && b < {1'b0, cur_stop}) begin
        span = {1'b0, cur_stop} - b;
        n = span >> PAGE_BITS;
      end
      if (n > NUM_PAGES) n = NUM_PAGES;
      lat_base  = b;
      lat_pages = n;
    end
  endtask

  // Drop valid and wait until every result has come back, plus a short margin.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_reg(pgalloc_pkg::reg_idx_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == pgalloc_pkg::REG_START) cur_start = v;
    else cur_stop = v;
    @(posedge clk);
  endtask

  // Pick one of the highest pages of the latched range: those are handed out
  // first, so most frees and references land on live pages.
  function automatic logic [31:0] hot_page();
    logic [31:0] r;
    logic [32:0] p;
    int unsigned k;
    if (lat_pages == 0) begin
      r = $urandom;
      r[PAGE_BITS-1:0] = '0;
      return r;
    end
    k = $urandom_range(0, (lat_pages > 8) ? 7 : lat_pages - 1);
    p = lat_base + (33'(lat_pages - 1 - k) << PAGE_BITS);
    return p[31:0];
  endfunction

  // Addresses that should mostly be rejected: random, misaligned, past the end,
  // just below the base.
  function automatic logic [31:0] noise_addr();
    logic [32:0] p;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return hot_page() | 32'($urandom_range(1, (1 << PAGE_BITS) - 1));
      2: begin
        p = lat_base + (33'(lat_pages) << PAGE_BITS);
        return p[31:0];
      end
      default: begin
        p = lat_base - (33'd1 << PAGE_BITS);
        return p[31:0];
      end
    endcase
  endfunction

  // One configuration phase: write the registers while idle, send a couple of
  // requests that must still see the old range, init, then random traffic.
  task automatic run_phase(logic [31:0] s, logic [31:0] e, int n);
    int r;
    drain();
    write_reg(pgalloc_pkg::REG_START, s);
    write_reg(pgalloc_pkg::REG_STOP, e);
    send_request(pgalloc_pkg::CMD_FREE, hot_page());
    send_request(pgalloc_pkg::CMD_ALLOC, $urandom);
    send_request(pgalloc_pkg::CMD_INIT, $urandom);
    repeat (n) begin
      r = $urandom_range(0, 199);
      if (r == 0)
        send_request(pgalloc_pkg::CMD_INIT, $urandom);
      else if (r < 70)
        send_request(pgalloc_pkg::CMD_ALLOC, $urandom);
      else if (r < 120)
        send_request(pgalloc_pkg::CMD_FREE, hot_page());
      else if (r < 160)
        send_request(pgalloc_pkg::CMD_ADDREF, hot_page());
      else if (r < 180)
        send_request(pgalloc_pkg::cmd_t'($urandom_range(1, 2)), noise_addr());
      else
        send_request(pgalloc_pkg::cmd_t'($urandom_range(0, 2)), $urandom);
    end
  endtask

  initial begin
    logic [31:0] top;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset range. The core runs its clearing pass
    // first; the handshake simply holds until it is done.
    top = hot_page() | '0;
    top = lat_base[31:0] + ((lat_pages - 1) << PAGE_BITS);
    send_request(pgalloc_pkg::CMD_ALLOC, 32'hFFFF_FFFF);      // fresh page from the top
    send_request(pgalloc_pkg::CMD_FREE, top);                 // back to the pool
    send_request(pgalloc_pkg::CMD_FREE, top);                 // count already zero
    send_request(pgalloc_pkg::CMD_ALLOC, 32'h0000_0000);      // pop the returned page
    send_request(pgalloc_pkg::CMD_ADDREF, top);
    send_request(pgalloc_pkg::CMD_ADDREF, top);
    send_request(pgalloc_pkg::CMD_FREE, top);
    send_request(pgalloc_pkg::CMD_FREE, top);
    send_request(pgalloc_pkg::CMD_FREE, top);                 // reaches zero, pushed
    send_request(pgalloc_pkg::CMD_ADDREF, top);               // reference to a pooled page
    send_request(pgalloc_pkg::CMD_FREE, top);                 // pushed a second time
    send_request(pgalloc_pkg::CMD_ALLOC, $urandom);
    send_request(pgalloc_pkg::CMD_ALLOC, $urandom);
    send_request(pgalloc_pkg::CMD_FREE, top | 32'h0000_0800); // misaligned
    // below base
    send_request(pgalloc_pkg::CMD_ADDREF, lat_base[31:0] - 32'h0000_1000);
    send_request(pgalloc_pkg::CMD_ADDREF, cur_stop);          // first page past the range
    send_request(pgalloc_pkg::CMD_FREE, 32'hFFFF_FFFF);
    send_request(pgalloc_pkg::CMD_ADDREF, 32'h0000_0000);
    send_request(pgalloc_pkg::CMD_ADDREF, lat_base[31:0]);    // lowest managed page
    send_request(pgalloc_pkg::CMD_FREE, top - 32'h0000_1000); // never handed out
    send_request(pgalloc_pkg::CMD_INIT, 32'hFFFF_FFFF);

    // Four pages with a start that needs rounding: out of memory comes quickly.
    run_phase(32'h0000_1001, 32'h0000_6000, 30);
    // Hammer one page past the saturation point.
    top = hot_page();
    repeat (pgalloc_pkg::COUNT_MAX + 2) send_request(pgalloc_pkg::CMD_ADDREF, top);
    // Whole address space: page count clamps to the store depth.
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 30);
    // Rounded start overflows 32 bits: empty range.
    run_phase(32'hFFFF_F001, 32'hFFFF_FFFF, 30);
    // Top of the address space, fifteen pages.
    run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 30);
    // Random start with a small span; may wrap and come out empty.
    begin
      logic [31:0] s;
      s = $urandom;
      run_phase(s, s + (32'($urandom_range(1, 40)) << PAGE_BITS), 30);
    end
    // Start above stop: empty range.
    run_phase(32'h9000_0000, 32'h1000_0000, 30);
    // Back to the reset values.
    run_phase(pgalloc_pkg::START_RST, pgalloc_pkg::STOP_RST, 30);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
